>>> sv/gf2_back_substitution_macros.svh
// ---------------------------------------------------------------------------
// GF(2) back substitution assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef GF2_BACK_SUBSTITUTION_MACROS_SVH
`define GF2_BACK_SUBSTITUTION_MACROS_SVH

// Property checked at every clock edge outside reset.
`define GFBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Trigger condition implies the consequence in the following cycle.
`define GFBS_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/gfbs_pkg.sv
// ---------------------------------------------------------------------------
// GF(2) back substitution package
// Shared widths, codes, and inter-module structs.
// ---------------------------------------------------------------------------
package gfbs_pkg;

	localparam int MAX_VARS     = 1024;
	localparam int MAX_RHS_BITS = 64;
	localparam int WORD_BITS    = 64;
	localparam int BIT_W        = 6;   // log2 of the row word width
	localparam int IDX_W        = 10;
	localparam int WIDX_W       = 5;
	localparam int COL_W        = WIDX_W + BIT_W;
	localparam int VAR_W        = 11;
	localparam int RHS_W        = 7;

	// configuration register indexes
	localparam logic REG_VAR_COUNT = 1'b0;
	localparam logic REG_RHS_COUNT = 1'b1;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_ROW   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_READ   = 2'd0,
		STS_SOLVED = 2'd1,
		STS_EMPTY  = 2'd2,
		STS_UNSAT  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_READ
	} state_t;

	// effective configuration, already clamped
	typedef struct packed {
		logic [VAR_W-1:0] var_eff;
		logic [RHS_W-1:0] rhs_eff;
	} cfg_t;

	typedef struct packed {
		logic                 valid;
		logic [1:0]           status;
		logic [IDX_W-1:0]     pivot_index;
		logic [WORD_BITS-1:0] value;
	} res_t;

endpackage

>>> sv/gfbs_in_if.sv
// ---------------------------------------------------------------------------
// GF(2) back substitution input channel
// valid/ready channel carrying one command transaction.
// ---------------------------------------------------------------------------
interface gfbs_in_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          command;
	logic [gfbs_pkg::IDX_W-1:0]          entry_index;
	logic [gfbs_pkg::WORD_BITS-1:0]      entry_value;
	logic [gfbs_pkg::WIDX_W-1:0]         word_index;
	logic [gfbs_pkg::WORD_BITS-1:0]      word_data;
	logic                                word_last;

	modport source (output valid, command, entry_index, entry_value, word_index,
		word_data, word_last, input ready);
	modport sink (input valid, command, entry_index, entry_value, word_index,
		word_data, word_last, output ready);
endinterface

>>> sv/gfbs_out_if.sv
// ---------------------------------------------------------------------------
// GF(2) back substitution result channel
// valid/ready channel carrying one result transaction.
// ---------------------------------------------------------------------------
interface gfbs_out_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     status;
	logic [gfbs_pkg::IDX_W-1:0]     pivot_index;
	logic [gfbs_pkg::WORD_BITS-1:0] value;

	modport source (output valid, status, pivot_index, value, input ready);
	modport sink (input valid, status, pivot_index, value, output ready);
endinterface

>>> sv/gf2_back_substitution.sv
// ---------------------------------------------------------------------------
// GF(2) back substitution
// Streams echelon rows bottom-up and solves each pivot from the stored solution.
// ---------------------------------------------------------------------------
// Usage:
//  - in_ch carries command transactions: write entry, row word, read entry.
//    One is taken at a time; ready is high only while the sequencer is idle.
//  - out_ch returns one result per read and one per last row word, through
//    an output register, so the next command is taken while a result waits.
//  - Sequencing: a write or unused command completes in the idle state; a
//    read passes through the read state to the output register; a row word
//    is scanned, and the last word adds the finish state. The scan handles
//    one set bit per cycle, limited by the single read port of the solution RAM.
//  - write_enable/reg_index/write_data set var_count (0) and rhs_count (1);
//    write only while idle.
//  - Reset clears the sequencer, row parity, pivot tracking and the output
//    register; var_count returns to 1024 and rhs_count to 64. Solution RAM
//    contents are undefined until written.
//  - A stalled receiver holds the result; a second result then stalls the
//    sequencer until the register drains.
// ---------------------------------------------------------------------------
module gf2_back_substitution (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        write_enable,
	input  logic                        reg_index,
	input  logic [gfbs_pkg::VAR_W-1:0]  write_data,
	gfbs_in_if.sink                     in_ch,
	gfbs_out_if.source                  out_ch
);

	logic [gfbs_pkg::VAR_W-1:0]     var_count_q;
	logic [gfbs_pkg::RHS_W-1:0]     rhs_count_q;
	gfbs_pkg::cfg_t                 cfg;
	gfbs_pkg::res_t                 res;
	logic                           res_ready;

	logic                           out_valid_q;
	logic [1:0]                     out_status_q;
	logic [gfbs_pkg::IDX_W-1:0]     out_pivot_q;
	logic [gfbs_pkg::WORD_BITS-1:0] out_value_q;

	// config registers, raw as written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_count_q <= gfbs_pkg::VAR_W'(gfbs_pkg::MAX_VARS);
			rhs_count_q <= gfbs_pkg::RHS_W'(gfbs_pkg::MAX_RHS_BITS);
		end else if (write_enable) begin
			unique case (reg_index)
				gfbs_pkg::REG_VAR_COUNT: var_count_q <= write_data;
				gfbs_pkg::REG_RHS_COUNT: rhs_count_q <= write_data[gfbs_pkg::RHS_W-1:0];
			endcase
		end
	end

	// clamp to the supported ranges
	always_comb begin
		cfg.var_eff = (var_count_q > gfbs_pkg::VAR_W'(gfbs_pkg::MAX_VARS))
			? gfbs_pkg::VAR_W'(gfbs_pkg::MAX_VARS) : var_count_q;
		cfg.rhs_eff = (rhs_count_q > gfbs_pkg::RHS_W'(gfbs_pkg::MAX_RHS_BITS))
			? gfbs_pkg::RHS_W'(gfbs_pkg::MAX_RHS_BITS) : rhs_count_q;
	end

	gfbs_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_ch     (in_ch),
		.res       (res),
		.res_ready (res_ready)
	);

	// output register: loads when empty or draining
	assign res_ready = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_status_q <= res.status;
			out_pivot_q  <= res.pivot_index;
			out_value_q  <= res.value;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = out_status_q;
	assign out_ch.pivot_index = out_pivot_q;
	assign out_ch.value       = out_value_q;

endmodule

>>> sv/gfbs_ram.sv
// ---------------------------------------------------------------------------
// GF(2) back substitution RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module gfbs_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/gfbs_engine.sv
// ---------------------------------------------------------------------------
// GF(2) back substitution engine
// Command sequencer: bit-per-cycle row scan over the solution RAM.
// ---------------------------------------------------------------------------
`include "gf2_back_substitution_macros.svh"

module gfbs_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  gfbs_pkg::cfg_t  cfg,
	gfbs_in_if.sink         in_ch,
	output gfbs_pkg::res_t  res,
	input  logic            res_ready
);

	localparam int W = gfbs_pkg::WORD_BITS;

	gfbs_pkg::state_t state_q, state_d;
	gfbs_pkg::cmd_t   cmd_w;

	logic [W-1:0]                    bits_q;
	logic [gfbs_pkg::WIDX_W-1:0]     wi_q;
	logic                            last_q;
	logic [W-1:0]                    parity_q, parity_d;
	logic                            pivot_seen_q;
	logic [gfbs_pkg::IDX_W-1:0]      pivot_col_q;
	logic [gfbs_pkg::IDX_W-1:0]      idx_q;
	logic                            rd_pend_s1;

	logic                            accept;
	logic                            any_bit;
	logic [gfbs_pkg::BIT_W-1:0]      k_w;
	logic [gfbs_pkg::COL_W-1:0]      col_w;
	logic [gfbs_pkg::COL_W-1:0]      rel_w;
	logic                            col_var;
	logic                            col_rhs;
	logic                            scan_step;
	logic                            scan_read;
	logic [W-1:0]                    rhs_toggle;
	logic [W-1:0]                    rhs_mask;
	logic [W-1:0]                    par_w;
	logic                            row_done;

	logic                            ram_we, ram_re;
	logic [gfbs_pkg::IDX_W-1:0]      ram_waddr, ram_raddr;
	logic [W-1:0]                    ram_wdata, ram_rdata;

	function automatic logic [gfbs_pkg::BIT_W-1:0] lowest_set(input logic [W-1:0] b);
		logic [gfbs_pkg::BIT_W-1:0] r;
		r = '0;
		for (int i = W - 1; i >= 0; i--) begin
			if (b[i]) r = gfbs_pkg::BIT_W'(i);
		end
		return r;
	endfunction

	gfbs_ram #(.DEPTH(gfbs_pkg::MAX_VARS), .WIDTH(W)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cmd_w  = gfbs_pkg::cmd_t'(in_ch.command);
	assign accept = in_ch.valid && in_ch.ready;

	// column decode of the lowest pending bit
	assign any_bit   = |bits_q;
	assign k_w       = lowest_set(bits_q);
	assign col_w     = {wi_q, k_w};
	assign rel_w     = col_w - cfg.var_eff;
	assign col_var   = col_w < cfg.var_eff;
	assign col_rhs   = !col_var && (rel_w < gfbs_pkg::COL_W'(cfg.rhs_eff));
	assign scan_step = (state_q == gfbs_pkg::ST_SCAN) && any_bit;
	assign scan_read = scan_step && col_var && pivot_seen_q;

	assign rhs_toggle = (scan_step && col_rhs) ? (W'(1) << rel_w[gfbs_pkg::BIT_W-1:0]) : '0;
	assign rhs_mask   = cfg.rhs_eff[gfbs_pkg::RHS_W-1] ? '1
		: ((W'(1) << cfg.rhs_eff[gfbs_pkg::BIT_W-1:0]) - W'(1));
	assign par_w      = parity_q & rhs_mask;
	assign row_done   = (state_q == gfbs_pkg::ST_FINISH) && res_ready;

	always_comb begin
		parity_d = parity_q ^ rhs_toggle ^ (rd_pend_s1 ? ram_rdata : '0);
		if (row_done) parity_d = '0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gfbs_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (cmd_w)
						gfbs_pkg::CMD_ROW:   state_d = gfbs_pkg::ST_SCAN;
						gfbs_pkg::CMD_READ:  state_d = gfbs_pkg::ST_READ;
						gfbs_pkg::CMD_WRITE: state_d = gfbs_pkg::ST_IDLE;
						gfbs_pkg::CMD_NONE:  state_d = gfbs_pkg::ST_IDLE;
					endcase
				end
			end
			gfbs_pkg::ST_SCAN: begin
				if (!any_bit) state_d = last_q ? gfbs_pkg::ST_FINISH : gfbs_pkg::ST_IDLE;
			end
			gfbs_pkg::ST_FINISH: begin
				if (res_ready) state_d = gfbs_pkg::ST_IDLE;
			end
			gfbs_pkg::ST_READ: begin
				if (res_ready) state_d = gfbs_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ch.ready     = 1'b0;
		ram_we          = 1'b0;
		ram_waddr       = in_ch.entry_index;
		ram_wdata       = in_ch.entry_value;
		ram_re          = scan_read;
		ram_raddr       = col_w[gfbs_pkg::IDX_W-1:0];
		res.valid       = 1'b0;
		res.status      = gfbs_pkg::STS_READ;
		res.pivot_index = idx_q;
		res.value       = ram_rdata;
		unique case (state_q)
			gfbs_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				ram_we      = accept && (cmd_w == gfbs_pkg::CMD_WRITE);
				ram_re      = accept && (cmd_w == gfbs_pkg::CMD_READ);
				ram_raddr   = in_ch.entry_index;
			end
			gfbs_pkg::ST_SCAN: begin
			end
			gfbs_pkg::ST_FINISH: begin
				res.valid = 1'b1;
				res.value = par_w;
				ram_waddr = pivot_col_q;
				ram_wdata = par_w;
				ram_we    = res_ready && pivot_seen_q;
				priority if (pivot_seen_q) begin
					res.status      = gfbs_pkg::STS_SOLVED;
					res.pivot_index = pivot_col_q;
				end else if (par_w != '0) begin
					res.status      = gfbs_pkg::STS_UNSAT;
					res.pivot_index = '0;
				end else begin
					res.status      = gfbs_pkg::STS_EMPTY;
					res.pivot_index = '0;
				end
			end
			gfbs_pkg::ST_READ: begin
				res.valid = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= gfbs_pkg::ST_IDLE;
			parity_q     <= '0;
			pivot_seen_q <= 1'b0;
			pivot_col_q  <= '0;
			rd_pend_s1   <= 1'b0;
		end else begin
			state_q    <= state_d;
			parity_q   <= parity_d;
			rd_pend_s1 <= scan_read;
			if (scan_step && col_var && !pivot_seen_q) begin
				pivot_seen_q <= 1'b1;
				pivot_col_q  <= col_w[gfbs_pkg::IDX_W-1:0];
			end else if (row_done) begin
				pivot_seen_q <= 1'b0;
				pivot_col_q  <= '0;
			end
		end
	end

	// word and index holding registers
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= in_ch.entry_index;
			if (cmd_w == gfbs_pkg::CMD_ROW) begin
				bits_q <= in_ch.word_data;
				wi_q   <= in_ch.word_index;
				last_q <= in_ch.word_last;
			end
		end else if (scan_step) begin
			bits_q <= bits_q & ~(W'(1) << k_w);
		end
	end

	`GFBS_ASSERT(a_ram_port_excl, !(ram_we && ram_re), "RAM read and write in one cycle")
	`GFBS_ASSERT_NEXT(a_read_answers, accept && (cmd_w == gfbs_pkg::CMD_READ), res.valid, "read gave no result")
	`GFBS_ASSERT(a_pend_from_scan, rd_pend_s1 |-> $past(state_q == gfbs_pkg::ST_SCAN), "stray RAM read")
	`GFBS_ASSERT_NEXT(a_row_cleared, row_done, !pivot_seen_q && (parity_q == '0), "row state not cleared")

endmodule
